/* hw/rtl/plcgdi_pkg.sv */
// ----------------------------------------------------------------------------
// plcgdi_pkg
// Shared types, constants and helpers for the pruned LCG block deinterleaver.
// ----------------------------------------------------------------------------
package plcgdi_pkg;

  localparam int unsigned MaxBlockDefault  = 32768;
  localparam int unsigned DataWidthDefault = 8;

  localparam int unsigned BlockLenW     = 16;
  localparam int unsigned DataOutW      = 8;
  localparam int unsigned OutPosW       = 15;
  localparam int unsigned MinBlock      = 5;
  localparam int unsigned QueueDepth    = 2;
  localparam logic [BlockLenW-1:0] BlockLenReset = 16'h8000;

  typedef enum logic {
    FE_ACCEPT,
    FE_SEARCH
  } front_state_e;

  // readout side of one queued word
  typedef struct packed {
    logic               emit;
    logic               last;
    logic [OutPosW-1:0] position;
  } meta_t;

  // s - 1 for s the next power of two at or above n, never below 8
  function automatic logic [31:0] span_mask(input logic [31:0] n);
    logic [31:0] x;
    x = n - 32'd1;
    x = x | (x >> 1);
    x = x | (x >> 2);
    x = x | (x >> 4);
    x = x | (x >> 8);
    x = x | (x >> 16);
    return x | 32'd7;
  endfunction

endpackage

/* hw/rtl/plcgdi_front.sv */
// ----------------------------------------------------------------------------
// plcgdi_front
// Accepts words, tracks block state and walks the pruned write sequence.
// ----------------------------------------------------------------------------
module plcgdi_front #(
  parameter int unsigned MAX_BLOCK  = plcgdi_pkg::MaxBlockDefault,
  parameter int unsigned DATA_WIDTH = plcgdi_pkg::DataWidthDefault,
  parameter int unsigned LEN_W      = $clog2(MAX_BLOCK + 1),
  parameter int unsigned POS_W      = $clog2(MAX_BLOCK)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  restart_i,
  input  logic [LEN_W-1:0]      n_i,
  input  logic [POS_W-1:0]      mask_i,
  input  logic                  in_valid_i,
  input  logic [DATA_WIDTH-1:0] data_in_i,
  output logic                  in_stall_o,
  input  logic                  q_full_i,
  output logic                  push_o,
  output logic [DATA_WIDTH-1:0] push_data_o,
  output logic [POS_W:0]        push_wr_addr_o,
  output logic [POS_W:0]        push_rd_addr_o,
  output plcgdi_pkg::meta_t     push_meta_o
);
  import plcgdi_pkg::*;

  front_state_e      state_q, state_d;
  logic [LEN_W-1:0]  load_cnt_q, load_cnt_d;
  logic [LEN_W-1:0]  emit_cnt_q, emit_cnt_d;
  logic [POS_W-1:0]  lcg_q, lcg_d;
  logic              bank_q, bank_d;
  logic              ready_q, ready_d;

  logic [POS_W-1:0]  g;
  logic [POS_W-1:0]  p_next;
  logic              p_ok;
  logic              accept;
  logic              emit;
  logic [LEN_W-1:0]  load_next;
  logic              wrap;

  assign g         = mask_i >> 2;
  // (5p + g) mod s; wrapping at 2^POS_W is harmless as s divides it
  assign p_next    = (lcg_q + {lcg_q[POS_W-3:0], 2'b00} + g) & mask_i;
  assign p_ok      = LEN_W'(p_next) < n_i;
  assign accept    = (state_q == FE_ACCEPT) && in_valid_i && !q_full_i;
  assign emit      = ready_q && (emit_cnt_q < n_i);
  assign load_next = load_cnt_q + 1'b1;
  assign wrap      = load_next >= n_i;

  assign in_stall_o     = !((state_q == FE_ACCEPT) && !q_full_i);
  assign push_o         = accept;
  assign push_data_o    = data_in_i;
  assign push_wr_addr_o = {bank_q, lcg_q};
  assign push_rd_addr_o = {~bank_q, emit_cnt_q[POS_W-1:0]};

  always_comb begin
    push_meta_o.emit     = emit;
    push_meta_o.last     = emit_cnt_q == (n_i - 1'b1);
    push_meta_o.position = OutPosW'(emit_cnt_q);
  end

  always_comb begin
    state_d    = state_q;
    load_cnt_d = load_cnt_q;
    emit_cnt_d = emit_cnt_q;
    lcg_d      = lcg_q;
    bank_d     = bank_q;
    ready_d    = ready_q;
    unique case (state_q)
      FE_ACCEPT: begin
        if (accept) begin
          if (emit) begin
            emit_cnt_d = emit_cnt_q + 1'b1;
          end
          if (wrap) begin
            bank_d     = ~bank_q;
            ready_d    = 1'b1;
            emit_cnt_d = '0;
            load_cnt_d = '0;
            lcg_d      = '0;
          end else begin
            load_cnt_d = load_next;
            lcg_d      = p_next;
            if (!p_ok) begin
              state_d = FE_SEARCH;
            end
          end
        end
      end
      FE_SEARCH: begin
        // skip generator values at or above the block length
        lcg_d = p_next;
        if (p_ok) begin
          state_d = FE_ACCEPT;
        end
      end
      default: state_d = FE_ACCEPT;
    endcase
    if (restart_i) begin
      state_d    = FE_ACCEPT;
      load_cnt_d = '0;
      emit_cnt_d = '0;
      lcg_d      = '0;
      ready_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= FE_ACCEPT;
      load_cnt_q <= '0;
      emit_cnt_q <= '0;
      lcg_q      <= '0;
      bank_q     <= 1'b0;
      ready_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      emit_cnt_q <= emit_cnt_d;
      lcg_q      <= lcg_d;
      bank_q     <= bank_d;
      ready_q    <= ready_d;
    end
  end

endmodule

/* hw/rtl/plcgdi_queue.sv */
// ----------------------------------------------------------------------------
// plcgdi_queue
// Two-entry word queue between the front and the back.
// ----------------------------------------------------------------------------
module plcgdi_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o,
  input  logic             pop_i
);
  import plcgdi_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic [WIDTH-1:0] slot_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = cnt_q == CntW'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* hw/rtl/plcgdi_back.sv */
// ----------------------------------------------------------------------------
// plcgdi_back
// Bank memory: writes each queued word, reads the natural-order word back
// and holds the result in an output register.
// ----------------------------------------------------------------------------
module plcgdi_back #(
  parameter int unsigned DATA_WIDTH = plcgdi_pkg::DataWidthDefault,
  parameter int unsigned ADDR_W     = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  logic [DATA_WIDTH-1:0]         q_data_i,
  input  logic [ADDR_W-1:0]             q_wr_addr_i,
  input  logic [ADDR_W-1:0]             q_rd_addr_i,
  input  plcgdi_pkg::meta_t             q_meta_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [plcgdi_pkg::DataOutW-1:0] data_out_o,
  output logic [plcgdi_pkg::OutPosW-1:0]  out_position_o,
  output logic                          block_last_o
);
  import plcgdi_pkg::*;

  localparam int unsigned Depth = 2 ** ADDR_W;

  logic [DATA_WIDTH-1:0] mem [Depth];
  logic [DATA_WIDTH-1:0] rdata_q;
  logic                  rd_valid_q;
  meta_t                 rd_meta_q;
  logic                  out_valid_q;
  logic [DataOutW-1:0]   out_data_q;
  logic [OutPosW-1:0]    out_pos_q;
  logic                  out_last_q;
  logic                  out_free;
  logic                  rd_free;
  logic                  rd_en;

  assign out_free = !out_valid_q || !out_stall_i;
  assign rd_free  = !rd_valid_q || out_free;
  assign q_pop_o  = q_valid_i && rd_free;
  assign rd_en    = q_pop_o && q_meta_i.emit;

  // write and read always hit opposite banks
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      mem[q_wr_addr_i] <= q_data_i;
    end
    if (rd_en) begin
      rdata_q <= mem[q_rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rd_free) begin
        rd_valid_q <= rd_en;
      end
      if (out_free) begin
        out_valid_q <= rd_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_meta_q <= q_meta_i;
    end
    if (out_free && rd_valid_q) begin
      out_data_q <= rdata_q[DataOutW-1:0];
      out_pos_q  <= rd_meta_q.position;
      out_last_q <= rd_meta_q.last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign data_out_o     = out_data_q;
  assign out_position_o = out_pos_q;
  assign block_last_o   = out_last_q;

endmodule

/* hw/rtl/pruned_lcg_block_deinterleaver_top.sv */
// Each taken word goes through the queue to the bank; the readout pushed with it
// passes the bank read and output registers. The front takes no new word while it
// skips generator values (one per cycle, by its sequence stepper) or the queue is full.
// Output order and rate follow the input; nothing leaves before the first block.
// Reset clears all control state; bank contents are undefined until written.
// ----------------------------------------------------------------------------
// pruned_lcg_block_deinterleaver_top
// Double-buffered pruned LCG block deinterleaver with a decoupled front/back.
// ----------------------------------------------------------------------------
module pruned_lcg_block_deinterleaver_top #(
  parameter int unsigned MAX_BLOCK  = plcgdi_pkg::MaxBlockDefault,
  parameter int unsigned DATA_WIDTH = plcgdi_pkg::DataWidthDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [plcgdi_pkg::BlockLenW-1:0] cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [DATA_WIDTH-1:0]            data_in_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [plcgdi_pkg::DataOutW-1:0]  data_out_o,
  output logic [plcgdi_pkg::OutPosW-1:0]   out_position_o,
  output logic                             block_last_o
);
  import plcgdi_pkg::*;

  localparam int unsigned LenW   = $clog2(MAX_BLOCK + 1);
  localparam int unsigned PosW   = $clog2(MAX_BLOCK);
  localparam int unsigned AddrW  = PosW + 1;
  localparam int unsigned MetaW  = $bits(meta_t);
  localparam int unsigned EntryW = DATA_WIDTH + 2 * AddrW + MetaW;

  logic [BlockLenW-1:0]  block_length_q;
  logic [LenW-1:0]       n_eff;
  logic [PosW-1:0]       span_m;

  logic                  push;
  logic                  q_full;
  logic [DATA_WIDTH-1:0] push_data;
  logic [AddrW-1:0]      push_wr_addr;
  logic [AddrW-1:0]      push_rd_addr;
  meta_t                 push_meta;
  logic                  q_valid;
  logic                  q_pop;
  logic [EntryW-1:0]     q_entry;
  logic [DATA_WIDTH-1:0] q_data;
  logic [AddrW-1:0]      q_wr_addr;
  logic [AddrW-1:0]      q_rd_addr;
  meta_t                 q_meta;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_length_q <= BlockLenReset;
    end else if (cfg_we_i) begin
      block_length_q <= cfg_wdata_i;
    end
  end

  // register keeps the raw value; the block runs on the clamped length
  always_comb begin
    if (32'(block_length_q) < MinBlock) begin
      n_eff = LenW'(MinBlock);
    end else if (32'(block_length_q) > MAX_BLOCK) begin
      n_eff = LenW'(MAX_BLOCK);
    end else begin
      n_eff = LenW'(block_length_q);
    end
  end

  assign span_m = PosW'(span_mask(32'(n_eff)));

  plcgdi_front #(
    .MAX_BLOCK  (MAX_BLOCK),
    .DATA_WIDTH (DATA_WIDTH),
    .LEN_W      (LenW),
    .POS_W      (PosW)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .restart_i      (cfg_we_i),
    .n_i            (n_eff),
    .mask_i         (span_m),
    .in_valid_i     (in_valid_i),
    .data_in_i      (data_in_i),
    .in_stall_o     (in_stall_o),
    .q_full_i       (q_full),
    .push_o         (push),
    .push_data_o    (push_data),
    .push_wr_addr_o (push_wr_addr),
    .push_rd_addr_o (push_rd_addr),
    .push_meta_o    (push_meta)
  );

  plcgdi_queue #(
    .WIDTH (EntryW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_data, push_wr_addr, push_rd_addr, push_meta}),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .data_o      (q_entry),
    .pop_i       (q_pop)
  );

  assign {q_data, q_wr_addr, q_rd_addr, q_meta} = q_entry;

  plcgdi_back #(
    .DATA_WIDTH (DATA_WIDTH),
    .ADDR_W     (AddrW)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_data_i       (q_data),
    .q_wr_addr_i    (q_wr_addr),
    .q_rd_addr_i    (q_rd_addr),
    .q_meta_i       (q_meta),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .data_out_o     (data_out_o),
    .out_position_o (out_position_o),
    .block_last_o   (block_last_o)
  );

  // a taken word always finds room in the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> !q_full)
    else $error("word accepted with queue full");

  // the block-end flag sits on the last natural position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && block_last_o) |-> (out_position_o == OutPosW'(n_eff - 1'b1)))
    else $error("block_last off the final position");

  // queued readouts only address positions inside the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid && q_meta.emit) |-> (LenW'(q_rd_addr[PosW-1:0]) < n_eff))
    else $error("readout beyond block length");

endmodule

/* bench/pruned_lcg_block_deinterleaver_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pruned_lcg_block_deinterleaver_top_tb
// Self-checking bench for the pruned LCG block deinterleaver. Words are fed
// through the valid/stall port while a local model of the double-buffered
// banks predicts each deinterleaved word; a monitor compares every word taken
// from the output with the oldest prediction. Covers the reset length, the
// shortest block, clamped and power-of-two boundary lengths, lengths changed
// mid-block, random sender gaps and receiver stalls, and the clamped longest
// length.
// ----------------------------------------------------------------------------
module pruned_lcg_block_deinterleaver_top_tb;
  import plcgdi_pkg::*;

  localparam int unsigned MaxBlk    = MaxBlockDefault;
  localparam int unsigned StuckLimit = 4000;

  typedef struct {
    logic [DataOutW-1:0] data;
    logic [OutPosW-1:0]  pos;
    logic                last;
  } deint_word_t;

  logic                 clk_i;
  logic                 rst_ni         = 1'b0;
  logic                 cfg_we_i       = 1'b0;
  logic [BlockLenW-1:0] cfg_wdata_i    = '0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_stall_o;
  logic [7:0]           data_in_i      = '0;
  logic                 out_valid_o;
  logic                 out_stall_i    = 1'b0;
  logic [DataOutW-1:0]  data_out_o;
  logic [OutPosW-1:0]   out_position_o;
  logic                 block_last_o;

  pruned_lcg_block_deinterleaver_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_in_i      (data_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .data_out_o     (data_out_o),
    .out_position_o (out_position_o),
    .block_last_o   (block_last_o)
  );

  // local model of the deinterleaver
  bit [7:0]             bank_mem [0:2*MaxBlk-1];
  logic [BlockLenW-1:0] len_reg    = BlockLenReset;
  int unsigned          fill_count = 0;
  int unsigned          write_pos  = 0;
  int unsigned          read_pos   = 0;
  bit                   load_sel   = 1'b0;
  bit                   have_block = 1'b0;

  deint_word_t due_words [$];
  int unsigned mismatches     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned stuck_cycles   = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned clamp_len(input logic [BlockLenW-1:0] v);
    int unsigned n;
    n = 32'(v);
    if (n < MinBlock) n = MinBlock;
    if (n > MaxBlk) n = MaxBlk;
    return n;
  endfunction

  function automatic int unsigned span_for(input int unsigned n);
    int unsigned s;
    s = 8;
    while (s < n) s = s << 1;
    return s;
  endfunction

  // cycles to let the front finish its sequence search once results are in
  function automatic int unsigned settle_cycles();
    int unsigned n;
    n = clamp_len(len_reg);
    return span_for(n) - n + 16;
  endfunction

  function automatic void deinterleave_step(input logic [7:0] d);
    int unsigned n, s, g, p, k;
    deint_word_t w;
    n = clamp_len(len_reg);
    s = span_for(n);
    g = s / 4 - 1;
    if (have_block && read_pos < n) begin
      w.data = bank_mem[load_sel ? read_pos : MaxBlk + read_pos];
      w.pos  = read_pos[OutPosW-1:0];
      w.last = (read_pos == n - 1);
      due_words.push_back(w);
      read_pos++;
    end
    if (write_pos < n) bank_mem[load_sel ? MaxBlk + write_pos : write_pos] = d;
    fill_count++;
    if (fill_count >= n) begin
      load_sel   = ~load_sel;
      have_block = 1'b1;
      read_pos   = 0;
      fill_count = 0;
      write_pos  = 0;
    end else begin
      p = write_pos;
      for (k = 0; k < s; k++) begin
        p = (p * 5 + g) & (s - 1);
        if (p < n) break;
      end
      write_pos = p;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic send_word(input logic [7:0] d);
    bit go;
    go = 1'b0;
    while (!go) begin
      @(negedge clk_i);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i <= 1'b1;
        data_in_i  <= d;
        go = 1'b1;
      end
    end
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    deinterleave_step(d);
  endtask

  // sender holds off until every predicted word has left the block
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (due_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_block_length(input logic [BlockLenW-1:0] v);
    drain_results();
    repeat (settle_cycles()) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    len_reg    = v;
    fill_count = 0;
    write_pos  = 0;
    read_pos   = 0;
    have_block = 1'b0;
  endtask

  // length left at its reset value: a partial block, nothing comes out
  task automatic test_reset_length();
    int i;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (i = 0; i < 40; i++) send_word(8'($urandom_range(0, 255)));
  endtask

  task automatic test_shortest_block();
    logic [7:0] pattern [20];
    int i;
    pattern = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h0F, 8'hF0,
                8'h33, 8'hCC, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'hFD, 8'hBF};
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_block_length(BlockLenW'(MinBlock));
    for (i = 0; i < 20; i++) send_word(pattern[i]);
  endtask

  task automatic test_random_blocks();
    int unsigned boundary_lens [10];
    int unsigned phase, sent, pause_at, n, count, i, r;
    logic [BlockLenW-1:0] raw;
    boundary_lens = '{5, 6, 7, 8, 9, 15, 16, 17, 31, 33};
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      sent     = 0;
      pause_at = $urandom_range(20, 90);
      while (sent < 100) begin
        r = $urandom_range(0, 9);
        if (r == 0) raw = BlockLenW'($urandom_range(0, MinBlock - 1));
        else if (r < 5) raw = BlockLenW'(boundary_lens[$urandom_range(0, 9)]);
        else raw = BlockLenW'($urandom_range(5, 40));
        write_block_length(raw);
        n = clamp_len(raw);
        // whole blocks plus a tail that the next length change throws away
        count = n * $urandom_range(2, 3) + $urandom_range(0, n - 1);
        for (i = 0; i < count && sent < 100; i++) begin
          if (sent == pause_at) drain_results();
          send_word(8'($urandom_range(0, 255)));
          sent++;
        end
      end
    end
  endtask

  // all-ones length clamps to the largest block; a partial load gives no readout
  task automatic test_longest_block();
    int unsigned i;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_block_length('1);
    for (i = 0; i < 20; i++) send_word(8'($urandom_range(0, 255)));
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin : check_proc
    deint_word_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_words.size() == 0) begin
        report_mismatch($sformatf("word at position %0d with none due", out_position_o));
      end else begin
        w = due_words.pop_front();
        if (data_out_o !== w.data)
          report_mismatch($sformatf("pos %0d data %h, want %h", w.pos, data_out_o, w.data));
        if (out_position_o !== w.pos)
          report_mismatch($sformatf("position %0d, want %0d", out_position_o, w.pos));
        if (block_last_o !== w.last)
          report_mismatch($sformatf("pos %0d last %b, want %b", w.pos, block_last_o, w.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= StuckLimit) begin
        $display("** pruned_lcg_block_deinterleaver_top: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_length();
    test_shortest_block();
    test_random_blocks();
    test_longest_block();
    drain_results();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** pruned_lcg_block_deinterleaver_top: PASSED **");
    end else begin
      $display("** pruned_lcg_block_deinterleaver_top: FAILED **");
    end
    $finish;
  end

endmodule
